// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the positional list engine.
// Expects clk_i and the active-low reset rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  `ASSERT_PROP(label, (ante) |=> (cons), msg)

`endif

// ===== hw/rtl/ple_pkg.sv =====
// Package for the positional list engine: field widths, opcode and status codes.
// No dependencies; used by the channel interfaces and the top level.
package ple_pkg;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_POS   = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

endpackage

// ===== hw/rtl/ple_if.sv =====
// Valid/ready channel interfaces of the positional list engine: request and response words.
// Depends on ple_pkg for the field widths.
interface ple_req_if import ple_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [VALUE_W-1:0]  value;
  logic [POS_W-1:0]    position;

  modport source (output valid, opcode, value, position, input ready);
  modport sink   (input valid, opcode, value, position, output ready);
endinterface

interface ple_rsp_if import ple_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  element_count;

  modport source (output valid, status, element_count, input ready);
  modport sink   (input valid, status, element_count, output ready);
endinterface

// ===== hw/rtl/positional_list_engine.sv =====
// Positional list engine top level: ordered list of DEPTH words with insert/delete by position.
// Depends on ple_pkg, ple_req_if, ple_rsp_if and assert_macros.svh.
//
// Takes one request word per cycle while the response side is not stalled, and returns one
// response word per request. The accepting edge loads the input register and the firing edge
// then loads the response register, which holds the response valid until it is taken. Each
// request compares every list cell's index against the target position and shifts or holds
// all cells in the same cycle as the count update, which sets the rate of one word per
// cycle while not stalled. A stalled response side holds one word in the response register
// and one in the input register before ready drops. List contents start undefined; of the
// list state, only the count is cleared by reset.
`include "assert_macros.svh"

module positional_list_engine import ple_pkg::*; #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ple_req_if.sink   req_i,
  ple_rsp_if.source rsp_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned PW    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  logic                  s1_valid_q;
  logic [OPCODE_W-1:0]   s1_op_q;
  logic [DATA_WIDTH-1:0] s1_value_q;
  logic [POS_W-1:0]      s1_pos_q;

  logic                  rsp_valid_q, rsp_valid_d;
  status_e               rsp_status_q;
  logic [CNT_W-1:0]      rsp_count_q;

  logic [CNT_W-1:0]      count_q, count_d;
  logic [DATA_WIDTH-1:0] entries_q [DEPTH];
  logic [DATA_WIDTH-1:0] entries_d [DEPTH];

  logic                  fire;
  logic                  req_accept;
  logic                  is_ins, is_del;
  logic                  do_ins, do_del;
  logic [PW-1:0]         cnt_ext;
  logic [PW-1:0]         eff_pos;
  logic [PW-1:0]         tgt_idx;
  status_e               status_d;

  assign fire        = s1_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_accept  = req_i.valid && req_i.ready;
  assign req_i.ready = !s1_valid_q || fire;
  assign cnt_ext     = PW'(count_q);

  always_comb begin
    is_ins  = 1'b0;
    is_del  = 1'b0;
    eff_pos = PW'(s1_pos_q);
    case (s1_op_q)
      OP_INS_FRONT: begin
        is_ins  = 1'b1;
        eff_pos = PW'(1);
      end
      OP_INS_BACK: begin
        is_ins  = 1'b1;
        eff_pos = cnt_ext + PW'(1);
      end
      OP_INS_POS: begin
        is_ins = 1'b1;
      end
      OP_DEL_FRONT: begin
        is_del  = 1'b1;
        eff_pos = PW'(1);
      end
      OP_DEL_BACK: begin
        is_del  = 1'b1;
        eff_pos = cnt_ext;
      end
      OP_DEL_POS: begin
        is_del = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (is_ins) begin
      if (count_q == CNT_W'(DEPTH)) begin
        status_d = ST_FULL;
      end else if (eff_pos == '0 || eff_pos > cnt_ext + PW'(1)) begin
        status_d = ST_BADPOS;
      end else begin
        status_d = ST_DONE;
      end
    end else if (is_del) begin
      if (count_q == '0) begin
        status_d = ST_EMPTY;
      end else if (eff_pos == '0 || eff_pos > cnt_ext) begin
        status_d = ST_BADPOS;
      end else begin
        status_d = ST_DONE;
      end
    end else begin
      status_d = ST_BADPOS;
    end
  end

  assign do_ins  = fire && is_ins && (status_d == ST_DONE);
  assign do_del  = fire && is_del && (status_d == ST_DONE);
  assign tgt_idx = eff_pos - PW'(1);

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_del) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam logic [PW-1:0] IDX = PW'(g);
    logic [DATA_WIDTH-1:0] below_w;
    logic [DATA_WIDTH-1:0] above_w;

    if (g == 0) begin : g_lo
      assign below_w = entries_q[g];
    end else begin : g_lo
      assign below_w = entries_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_hi
      assign above_w = entries_q[g];
    end else begin : g_hi
      assign above_w = entries_q[g+1];
    end

    always_comb begin
      entries_d[g] = entries_q[g];
      if (do_ins) begin
        if (IDX == tgt_idx) begin
          entries_d[g] = s1_value_q;
        end else if (IDX > tgt_idx) begin
          entries_d[g] = below_w;
        end
      end else if (do_del) begin
        if (IDX >= tgt_idx) begin
          entries_d[g] = above_w;
        end
      end
    end
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (fire) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      rsp_valid_q <= rsp_valid_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      s1_op_q    <= req_i.opcode;
      s1_value_q <= DATA_WIDTH'(req_i.value);
      s1_pos_q   <= req_i.position;
    end
    if (fire) begin
      rsp_status_q <= status_d;
      rsp_count_q  <= count_d;
    end
    if (do_ins || do_del) begin
      entries_q <= entries_d;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = rsp_status_q;
  assign rsp_o.element_count = COUNT_W'(rsp_count_q);

  `ASSERT_PROP(a_count_bound, count_q <= CNT_W'(DEPTH), "count exceeds capacity")
  `ASSERT_NEXT(a_ins_count, do_ins, count_q == $past(count_q) + CNT_W'(1),
               "insert did not advance count")
  `ASSERT_NEXT(a_fail_hold, fire && (status_d != ST_DONE), count_q == $past(count_q),
               "failed operation changed count")
  `ASSERT_PROP(a_full_flag, (fire && status_d == ST_FULL) |-> (count_q == CNT_W'(DEPTH)),
               "full reported below capacity")

endmodule

// ===== bench/ple_list_checker.sv =====
// Response checker for the positional list engine: tracks the list from accepted requests
// and compares each response word against the oldest prediction.
// Depends on ple_pkg and the ple_req_if / ple_rsp_if channel interfaces.
module ple_list_checker import ple_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  ple_req_if   req_i,
  ple_rsp_if   rsp_i,
  output int   mismatches_o,
  output int   due_o,
  output int   list_len_o,
  output int   checked_o,
  output int   full_hits_o,
  output int   empty_hits_o
);

  typedef struct packed {
    status_e            status;
    logic [COUNT_W-1:0] element_count;
  } list_reply_t;

  list_reply_t        due_replies[$];
  logic [VALUE_W-1:0] list_words[DEPTH];
  int                 list_len = 0;
  int                 mismatch_count = 0;
  int                 due_count = 0;
  int                 checked_count = 0;
  int                 full_hits = 0;
  int                 empty_hits = 0;

  assign mismatches_o = mismatch_count;
  assign due_o        = due_count;
  assign list_len_o   = list_len;
  assign checked_o    = checked_count;
  assign full_hits_o  = full_hits;
  assign empty_hits_o = empty_hits;

  function automatic status_e insert_at(input int slot, input logic [VALUE_W-1:0] word);
    if (list_len >= DEPTH) return ST_FULL;
    if (slot < 1 || slot > list_len + 1) return ST_BADPOS;
    for (int i = list_len; i >= slot; i--) list_words[i] = list_words[i-1];
    list_words[slot-1] = word;
    list_len++;
    return ST_DONE;
  endfunction

  function automatic status_e remove_at(input int slot);
    if (list_len == 0) return ST_EMPTY;
    if (slot < 1 || slot > list_len) return ST_BADPOS;
    for (int i = slot - 1; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
    list_len--;
    return ST_DONE;
  endfunction

  function automatic status_e apply_list_op(input logic [OPCODE_W-1:0] op,
                                            input logic [VALUE_W-1:0]  word,
                                            input logic [POS_W-1:0]    pos);
    case (op)
      OP_INS_FRONT: return insert_at(1, word);
      OP_INS_BACK:  return insert_at(list_len + 1, word);
      OP_INS_POS:   return insert_at(int'(pos), word);
      OP_DEL_FRONT: return remove_at(1);
      OP_DEL_BACK:  return remove_at(list_len);
      OP_DEL_POS:   return remove_at(int'(pos));
      default:      return ST_BADPOS;
    endcase
  endfunction

  always @(posedge clk_i) begin
    list_reply_t want;
    if (rst_ni) begin
      if (req_i.valid && req_i.ready) begin
        want.status        = apply_list_op(req_i.opcode, req_i.value, req_i.position);
        want.element_count = COUNT_W'(list_len);
        if (want.status == ST_FULL) full_hits++;
        if (want.status == ST_EMPTY) empty_hits++;
        due_replies.push_back(want);
      end
      if (rsp_i.valid && rsp_i.ready) begin
        checked_count++;
        if (due_replies.size() == 0) begin
          $error("unexpected response word: status %0d, element_count %0d",
                 rsp_i.status, rsp_i.element_count);
          mismatch_count++;
        end else begin
          want = due_replies.pop_front();
          if (rsp_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_i.status);
            mismatch_count++;
          end
          if (rsp_i.element_count !== want.element_count) begin
            $error("element_count: expected %0d, got %0d",
                   want.element_count, rsp_i.element_count);
            mismatch_count++;
          end
        end
      end
      due_count = due_replies.size();
    end
  end

endmodule

// ===== bench/tb_positional_list_engine.sv =====
// Testbench top for the positional list engine: clock, reset, request and response drivers.
// Directed corner cases, then grow/shrink phases of random words; checking in ple_list_checker.
// Depends on ple_pkg, ple_req_if, ple_rsp_if, positional_list_engine and ple_list_checker.
module tb_positional_list_engine;
  import ple_pkg::*;

  localparam int unsigned       DEPTH       = 16;
  localparam int                RAND_WORDS  = 1350;
  localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

  logic clk_i;
  logic rst_ni;
  bit   steady;
  int   sent;
  int   mismatches;
  int   due;
  int   list_len;
  int   checked;
  int   full_hits;
  int   empty_hits;

  ple_req_if req_ch ();
  ple_rsp_if rsp_ch ();

  positional_list_engine #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (VALUE_W)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  ple_list_checker #(
    .DEPTH (DEPTH)
  ) u_list_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .mismatches_o (mismatches),
    .due_o        (due),
    .list_len_o   (list_len),
    .checked_o    (checked),
    .full_hits_o  (full_hits),
    .empty_hits_o (empty_hits)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 9);
  end

  initial begin
    #1_600_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_word(input logic [OPCODE_W-1:0] op,
                           input logic [VALUE_W-1:0]  word,
                           input logic [POS_W-1:0]    pos);
    while (!steady && $urandom_range(0, 99) < 9) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid    <= 1'b1;
    req_ch.opcode   <= op;
    req_ch.value    <= word;
    req_ch.position <= pos;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  function automatic logic [POS_W-1:0] pick_position(input bit for_insert);
    int top_slot;
    top_slot = for_insert ? list_len + 1 : list_len;
    if (top_slot < 1 || $urandom_range(0, 99) < 15) return POS_W'($urandom_range(0, 17));
    return POS_W'($urandom_range(1, top_slot));
  endfunction

  initial begin
    bit                  grow;
    bit                  is_insert;
    int                  roll;
    logic [OPCODE_W-1:0] op;
    rst_ni          = 1'b0;
    steady          = 1'b0;
    sent            = 0;
    req_ch.valid    = 1'b0;
    req_ch.opcode   = '0;
    req_ch.value    = '0;
    req_ch.position = '0;
    rsp_ch.ready    = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    send_word(OP_DEL_FRONT, '0, 5'd0);
    send_word(OP_DEL_BACK,  '0, 5'd0);
    send_word(OP_DEL_POS,   '0, 5'd17);
    send_word(OP_DEL_POS,   '0, 5'd0);
    send_word(OP_INS_POS,   32'h1234_5678, 5'd0);
    send_word(OP_INS_POS,   32'h1234_5678, 5'd2);
    send_word(OP_SPARE_LO,  32'hFFFF_FFFF, 5'd1);
    send_word(OP_INS_BACK,  32'hFFFF_FFFF, 5'd31);
    send_word(OP_INS_FRONT, 32'h0000_0000, 5'd0);
    send_word(OP_INS_POS,   32'hA5A5_A5A5, 5'd2);
    send_word(OP_INS_POS,   32'h5A5A_5A5A, 5'd4);
    send_word(OP_INS_POS,   32'h0F0F_0F0F, 5'd6);
    send_word(OP_DEL_POS,   '1, 5'd0);
    send_word(OP_DEL_POS,   '1, 5'd5);
    send_word(OP_DEL_POS,   '1, 5'd2);
    send_word(OP_DEL_FRONT, '1, 5'd16);
    send_word(OP_DEL_BACK,  '1, 5'd16);
    send_word(OP_SPARE_HI,  '1, 5'd16);
    send_word(OP_DEL_POS,   '0, 5'd1);
    send_word(OP_INS_POS,   32'h8000_0001, 5'd1);

    for (int n = 0; n < RAND_WORDS; n++) begin
      steady <= (n >= 500 && n < 800);
      grow = ((n / 60) % 2) == 0;
      roll = $urandom_range(0, 99);
      is_insert = 1'b0;
      if (roll < 4) begin
        op = roll[0] ? OP_SPARE_HI : OP_SPARE_LO;
      end else if ((roll < 74) == grow) begin
        is_insert = 1'b1;
        case ($urandom_range(0, 2))
          0:       op = OP_INS_FRONT;
          1:       op = OP_INS_BACK;
          default: op = OP_INS_POS;
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0:       op = OP_DEL_FRONT;
          1:       op = OP_DEL_BACK;
          default: op = OP_DEL_POS;
        endcase
      end
      send_word(op, $urandom(), pick_position(is_insert));
    end
    req_ch.valid <= 1'b0;

    wait (due == 0);
    repeat (6) @(posedge clk_i);
    $display("Sent %0d request words (directed, then grow/shrink random phases);", sent);
    $display("%0d responses checked.", checked);
    $display("List predicted full on %0d words and empty on %0d words.", full_hits, empty_hits);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
